[rtl/r2h_pkg.sv]
// shared constants, widths and types for the rgb to hsv converter
// no dependencies; used by every module of the block
`default_nettype none

package r2h_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int FULL         = (1 << CHANNEL_BITS) - 1;

  // hue quotient never exceeds 420, so nine quotient bits
  localparam int HUE_QBITS = 9;
  localparam int HUE_RANGE = 360;
  localparam int HUE_MUL   = 60;

  // sector offsets in units of delta (6 = 360 deg, 2 = 120 deg, 4 = 240 deg)
  localparam int SECTOR_RED   = 6;
  localparam int SECTOR_GREEN = 2;
  localparam int SECTOR_BLUE  = 4;

  localparam int TERM_W  = CHANNEL_BITS + 3;
  localparam int NUM_W   = CHANNEL_BITS + HUE_QBITS;
  localparam int SNUM_W  = 2 * CHANNEL_BITS;
  localparam int STAGES  = (HUE_QBITS > CHANNEL_BITS) ? HUE_QBITS : CHANNEL_BITS;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [CHANNEL_BITS-1:0] chan_t;

  typedef struct packed {
    logic [NUM_W-1:0]  hue_num;
    logic [SNUM_W-1:0] sat_num;
    chan_t             delta;
    chan_t             max;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  typedef struct packed {
    logic [NUM_W-1:0]     hue_num;
    logic [SNUM_W-1:0]    sat_num;
    chan_t                delta;
    chan_t                max;
    chan_t                hrem;
    logic [HUE_QBITS-1:0] hq;
    chan_t                srem;
    chan_t                sq;
  } stage_t;

endpackage

`default_nettype wire

[rtl/r2h_front.sv]
// front end: takes a pixel, finds max, min, delta and the hue sector
// and forms the hue and saturation dividends; depends on r2h_pkg
`default_nettype none

module r2h_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire r2h_pkg::chan_t red,
  input  wire r2h_pkg::chan_t green,
  input  wire r2h_pkg::chan_t blue,
  input  wire r2h_pkg::qstat_t qstat,
  output logic                push,
  output r2h_pkg::item_t      item
);

  localparam int TW = r2h_pkg::TERM_W;
  localparam int NW = r2h_pkg::NUM_W;
  localparam int SW = r2h_pkg::SNUM_W;

  logic           fvld;
  r2h_pkg::item_t fitem;
  r2h_pkg::item_t item_next;
  r2h_pkg::chan_t mx, mn, dl, p, n;
  logic [TW-1:0]  base, term;
  logic           accept;

  assign busy   = fvld && qstat.full;
  assign push   = fvld && !qstat.full;
  assign accept = start && !busy;
  assign item   = fitem;

  always_comb begin
    // ties: red over green, green over blue
    if (red >= green && red >= blue) begin
      mx   = red;
      base = TW'(r2h_pkg::SECTOR_RED);
      p    = green;
      n    = blue;
    end else if (green >= blue) begin
      mx   = green;
      base = TW'(r2h_pkg::SECTOR_GREEN);
      p    = blue;
      n    = red;
    end else begin
      mx   = blue;
      base = TW'(r2h_pkg::SECTOR_BLUE);
      p    = red;
      n    = green;
    end
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    dl   = mx - mn;
    term = base * TW'(dl) + TW'(p) - TW'(n);
    item_next.hue_num = NW'(term) * NW'(r2h_pkg::HUE_MUL);
    item_next.sat_num = SW'(r2h_pkg::FULL) * SW'(dl);
    item_next.delta   = dl;
    item_next.max     = mx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fvld <= 1'b0;
    end else if (accept) begin
      fvld <= 1'b1;
    end else if (push) begin
      fvld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fitem <= item_next;
    end
  end

endmodule

`default_nettype wire

[rtl/r2h_queue.sv]
// short queue between the front end and the divider back end
// depends on r2h_pkg
`default_nettype none

module r2h_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire r2h_pkg::item_t wdata,
  input  wire logic           pop,
  output r2h_pkg::item_t      head,
  output r2h_pkg::qstat_t     qstat
);

  localparam int D  = r2h_pkg::QUEUE_DEPTH;
  localparam int PW = r2h_pkg::QPTR_W;
  localparam int CW = r2h_pkg::QCNT_W;

  r2h_pkg::item_t mem [D];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign qstat.empty = (count == '0);
  assign qstat.full  = (count == CW'(D));
  assign head        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop) rd_ptr <= rd_ptr + PW'(1);
      count <= count + CW'(push) - CW'(pop);
    end
  end

  ap_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !qstat.full)
    else $error("queue push while full");
  ap_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !qstat.empty)
    else $error("queue pop while empty");

endmodule

`default_nettype wire

[rtl/r2h_back.sv]
// back end: pipelined restoring dividers for hue and saturation, one
// quotient bit per stage, then hue wrap and result register; depends on r2h_pkg
`default_nettype none

module r2h_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire r2h_pkg::item_t  head,
  input  wire r2h_pkg::qstat_t qstat,
  output logic                 pop,
  output logic                 done,
  output logic [8:0]           hue_degrees,
  output r2h_pkg::chan_t       saturation_scaled,
  output r2h_pkg::chan_t       value_scaled
);

  localparam int W  = r2h_pkg::CHANNEL_BITS;
  localparam int QB = r2h_pkg::HUE_QBITS;
  localparam int S  = r2h_pkg::STAGES;
  localparam int NW = r2h_pkg::NUM_W;
  localparam int SW = r2h_pkg::SNUM_W;

  r2h_pkg::stage_t st  [S+1];
  logic            vld [S+1];
  logic [QB-1:0]   hq_last;
  logic [QB-1:0]   hue_next;

  assign pop = !qstat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= pop;
    end
  end

  always_ff @(posedge clk) begin
    st[0].hue_num <= head.hue_num;
    st[0].sat_num <= head.sat_num;
    st[0].delta   <= head.delta;
    st[0].max     <= head.max;
    st[0].hrem    <= head.hue_num[NW-1:QB];
    st[0].hq      <= '0;
    st[0].srem    <= head.sat_num[SW-1:W];
    st[0].sq      <= '0;
  end

  for (genvar s = 0; s < S; s++) begin : g_stage
    r2h_pkg::chan_t hrem_n;
    logic [QB-1:0]  hq_n;
    r2h_pkg::chan_t srem_n;
    r2h_pkg::chan_t sq_n;

    if (s < QB) begin : g_hue
      always_comb begin
        logic [W:0] sh;
        logic [W:0] diff;
        sh   = {st[s].hrem, st[s].hue_num[QB-1-s]};
        diff = sh - {1'b0, st[s].delta};
        hq_n = st[s].hq;
        if (sh >= {1'b0, st[s].delta}) begin
          hrem_n          = diff[W-1:0];
          hq_n[QB-1-s]    = 1'b1;
        end else begin
          hrem_n = sh[W-1:0];
        end
      end
    end else begin : g_hue_hold
      assign hrem_n = st[s].hrem;
      assign hq_n   = st[s].hq;
    end

    if (s < W) begin : g_sat
      always_comb begin
        logic [W:0] sh;
        logic [W:0] diff;
        sh   = {st[s].srem, st[s].sat_num[W-1-s]};
        diff = sh - {1'b0, st[s].max};
        sq_n = st[s].sq;
        if (sh >= {1'b0, st[s].max}) begin
          srem_n      = diff[W-1:0];
          sq_n[W-1-s] = 1'b1;
        end else begin
          srem_n = sh[W-1:0];
        end
      end
    end else begin : g_sat_hold
      assign srem_n = st[s].srem;
      assign sq_n   = st[s].sq;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      st[s+1].hue_num <= st[s].hue_num;
      st[s+1].sat_num <= st[s].sat_num;
      st[s+1].delta   <= st[s].delta;
      st[s+1].max     <= st[s].max;
      st[s+1].hrem    <= hrem_n;
      st[s+1].hq      <= hq_n;
      st[s+1].srem    <= srem_n;
      st[s+1].sq      <= sq_n;
    end
  end

  // wrap into 0..359, gray pixels get hue 0
  assign hq_last = st[S].hq;
  always_comb begin
    if (st[S].delta == '0) begin
      hue_next = '0;
    end else if (hq_last >= QB'(r2h_pkg::HUE_RANGE)) begin
      hue_next = hq_last - QB'(r2h_pkg::HUE_RANGE);
    end else begin
      hue_next = hq_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[S];
    end
  end

  always_ff @(posedge clk) begin
    hue_degrees       <= hue_next;
    saturation_scaled <= (st[S].max == '0) ? '0 : st[S].sq;
    value_scaled      <= st[S].max;
  end

  ap_hue_range: assert property (@(posedge clk) disable iff (rst)
    done |-> hue_degrees < 9'(r2h_pkg::HUE_RANGE))
    else $error("hue out of range");
  ap_sat_black: assert property (@(posedge clk) disable iff (rst)
    done && value_scaled == '0 |-> saturation_scaled == '0)
    else $error("black pixel with nonzero saturation");
  ap_sat_le_full: assert property (@(posedge clk) disable iff (rst)
    done |-> saturation_scaled <= value_scaled || value_scaled != '0)
    else $error("saturation without value");
  ap_pipe_flow: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> $past(!qstat.empty))
    else $error("divider loaded without a queued beat");

endmodule

`default_nettype wire

[rtl/rgb_to_hsv_converter.sv]
// top level of the rgb to hsv converter: front end, queue, divider back end
// depends on r2h_pkg, r2h_front, r2h_queue, r2h_back
//
//   channel | ports                                          | handshake
//   pixel   | red, green, blue                               | start && !busy
//   result  | hue_degrees, saturation_scaled, value_scaled   | done, one cycle
//
// one pixel accepted per clock while busy is low; a result passes through these registers in order
// (front register, queue, divider input register, one divider stage per quotient bit, result register)
// the rate is set by the front register handing one beat a cycle to the queue
// rst is synchronous and clears the valid flags, done, and the queue pointers and count only
// the receiver cannot stall; busy rises only if the queue were to fill
`default_nettype none

module rgb_to_hsv_converter (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire r2h_pkg::chan_t red,
  input  wire r2h_pkg::chan_t green,
  input  wire r2h_pkg::chan_t blue,
  output logic                done,
  output logic [8:0]          hue_degrees,
  output r2h_pkg::chan_t      saturation_scaled,
  output r2h_pkg::chan_t      value_scaled
);

  r2h_pkg::qstat_t qstat;
  r2h_pkg::item_t  item;
  r2h_pkg::item_t  head;
  logic            push;
  logic            pop;

  r2h_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .red   (red),
    .green (green),
    .blue  (blue),
    .qstat (qstat),
    .push  (push),
    .item  (item)
  );

  r2h_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (item),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  r2h_back u_back (
    .clk               (clk),
    .rst               (rst),
    .head              (head),
    .qstat             (qstat),
    .pop               (pop),
    .done              (done),
    .hue_degrees       (hue_degrees),
    .saturation_scaled (saturation_scaled),
    .value_scaled      (value_scaled)
  );

endmodule

`default_nettype wire

[test/tb_rgb_to_hsv_converter.sv]
// self-checking testbench for rgb_to_hsv_converter: directed table, then random pixels
// depends on r2h_pkg and the rgb_to_hsv_converter rtl; results checked against a local model or typed-in values
module tb_rgb_to_hsv_converter;

  typedef struct packed {
    logic [8:0]     hue;
    r2h_pkg::chan_t sat;
    r2h_pkg::chan_t val;
  } hsv_t;

  typedef struct packed {
    r2h_pkg::chan_t r;
    r2h_pkg::chan_t g;
    r2h_pkg::chan_t b;
    logic           known;
    hsv_t           hsv;
  } pixel_row_t;

  localparam int RANDOM_PIXELS = 950;
  localparam int NUM_ROWS = 22;

  // known = 1 rows carry a typed-in result, the rest use the model
  localparam pixel_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, '{9'd0,   8'd0,   8'd0}},
    '{8'd255, 8'd255, 8'd255, 1'b1, '{9'd0,   8'd0,   8'd255}},
    '{8'd128, 8'd128, 8'd128, 1'b1, '{9'd0,   8'd0,   8'd128}},
    '{8'd1,   8'd1,   8'd1,   1'b1, '{9'd0,   8'd0,   8'd1}},
    '{8'd255, 8'd0,   8'd0,   1'b1, '{9'd0,   8'd255, 8'd255}},
    '{8'd0,   8'd255, 8'd0,   1'b1, '{9'd120, 8'd255, 8'd255}},
    '{8'd0,   8'd0,   8'd255, 1'b1, '{9'd240, 8'd255, 8'd255}},
    '{8'd255, 8'd255, 8'd0,   1'b1, '{9'd60,  8'd255, 8'd255}},
    '{8'd0,   8'd255, 8'd255, 1'b1, '{9'd180, 8'd255, 8'd255}},
    '{8'd255, 8'd0,   8'd255, 1'b1, '{9'd300, 8'd255, 8'd255}},
    '{8'd1,   8'd0,   8'd0,   1'b1, '{9'd0,   8'd255, 8'd1}},
    '{8'd0,   8'd0,   8'd1,   1'b1, '{9'd240, 8'd255, 8'd1}},
    '{8'd255, 8'd0,   8'd1,   1'b0, '0},
    '{8'd255, 8'd254, 8'd255, 1'b0, '0},
    '{8'd200, 8'd100, 8'd50,  1'b0, '0},
    '{8'd10,  8'd20,  8'd30,  1'b0, '0},
    '{8'd255, 8'd254, 8'd0,   1'b0, '0},
    '{8'd1,   8'd1,   8'd0,   1'b0, '0},
    '{8'd0,   8'd1,   8'd1,   1'b0, '0},
    '{8'd254, 8'd255, 8'd253, 1'b0, '0},
    '{8'd85,  8'd170, 8'd255, 1'b0, '0},
    '{8'd100, 8'd99,  8'd100, 1'b0, '0}
  };

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           start = 1'b0;
  r2h_pkg::chan_t red = '0;
  r2h_pkg::chan_t green = '0;
  r2h_pkg::chan_t blue = '0;
  logic           busy;
  logic           done;
  logic [8:0]     hue_degrees;
  r2h_pkg::chan_t saturation_scaled;
  r2h_pkg::chan_t value_scaled;

  hsv_t pending_hsv [$];
  int   errors = 0;
  bit   burst_mode = 1'b0;

  rgb_to_hsv_converter uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .red(red),
    .green(green),
    .blue(blue),
    .done(done),
    .hue_degrees(hue_degrees),
    .saturation_scaled(saturation_scaled),
    .value_scaled(value_scaled)
  );

  always #2 clk = ~clk;

  function automatic hsv_t convert_pixel(r2h_pkg::chan_t r, r2h_pkg::chan_t g,
                                         r2h_pkg::chan_t b);
    int   rr, gg, bb, mx, mn, dl, num, h;
    hsv_t res;
    rr = int'(r);
    gg = int'(g);
    bb = int'(b);
    mx = rr;
    if (gg > mx) mx = gg;
    if (bb > mx) mx = bb;
    mn = rr;
    if (gg < mn) mn = gg;
    if (bb < mn) mn = bb;
    dl = mx - mn;
    h = 0;
    if (dl != 0) begin
      // ties go red, then green
      if (mx == rr) num = 360 * dl + 60 * gg - 60 * bb;
      else if (mx == gg) num = 120 * dl + 60 * bb - 60 * rr;
      else num = 240 * dl + 60 * rr - 60 * gg;
      h = num / dl;
      if (h >= 360) h = h - 360;
    end
    res.hue = h[8:0];
    res.sat = (mx != 0) ? r2h_pkg::chan_t'((r2h_pkg::FULL * dl) / mx) : '0;
    res.val = r2h_pkg::chan_t'(mx);
    return res;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (burst_mode) return 0;
    roll = $urandom_range(0, 19);
    if (roll < 9) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // holds start across back-to-back beats, lowers it only for a gap
  task automatic send_pixel(input r2h_pkg::chan_t r, input r2h_pkg::chan_t g,
                            input r2h_pkg::chan_t b, input logic known,
                            input hsv_t given, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    red   <= r;
    green <= g;
    blue  <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_hsv.push_back(known ? given : convert_pixel(r, g, b));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_hsv.size() != 0) @(posedge clk);
  endtask

  task automatic random_pixel(output r2h_pkg::chan_t r, output r2h_pkg::chan_t g,
                              output r2h_pkg::chan_t b);
    r2h_pkg::chan_t corners [4];
    r2h_pkg::chan_t top;
    corners = '{8'd0, 8'd1, 8'd254, 8'd255};
    r = r2h_pkg::chan_t'($urandom);
    g = r2h_pkg::chan_t'($urandom);
    b = r2h_pkg::chan_t'($urandom);
    case ($urandom_range(0, 9))
      4: begin
        g = r;
        b = r;
      end
      5: begin
        top = r2h_pkg::chan_t'($urandom_range(1, 255));
        r = top;
        g = top;
        b = r2h_pkg::chan_t'($urandom_range(0, top));
        case ($urandom_range(0, 2))
          0: {r, b} = {b, r};
          1: {g, b} = {b, g};
          default: ;
        endcase
      end
      6: begin
        r = corners[$urandom_range(0, 3)];
        g = corners[$urandom_range(0, 3)];
        b = corners[$urandom_range(0, 3)];
      end
      7: begin
        r = r2h_pkg::chan_t'($urandom_range(0, 3));
        g = r2h_pkg::chan_t'($urandom_range(0, 3));
        b = r2h_pkg::chan_t'($urandom_range(0, 3));
      end
      8: begin
        // red largest with blue above green
        r = r2h_pkg::chan_t'($urandom_range(2, 255));
        b = r2h_pkg::chan_t'($urandom_range(1, r - 1));
        g = r2h_pkg::chan_t'($urandom_range(0, b - 1));
      end
      9: begin
        case ($urandom_range(0, 2))
          0: r = 8'd255;
          1: g = 8'd255;
          default: b = 8'd255;
        endcase
      end
      default: ;
    endcase
  endtask

  initial begin
    r2h_pkg::chan_t r, g, b;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      send_pixel(DIRECTED_ROWS[i].r, DIRECTED_ROWS[i].g, DIRECTED_ROWS[i].b,
                 DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].hsv, pick_gap());
    end
    drain_results();

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i % 64 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_PIXELS / 2) drain_results();
      random_pixel(r, g, b);
      send_pixel(r, g, b, 1'b0, '0, pick_gap());
    end

    drain_results();
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  always @(posedge clk) begin
    hsv_t want;
    if (!rst && done !== 1'b0) begin
      if (pending_hsv.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected: hue %0d sat %0d val %0d",
                 $time, hue_degrees, saturation_scaled, value_scaled);
      end else begin
        want = pending_hsv.pop_front();
        if (hue_degrees !== want.hue) begin
          errors++;
          $display("%0t: hue_degrees expected %0d actual %0d", $time, want.hue, hue_degrees);
        end
        if (saturation_scaled !== want.sat) begin
          errors++;
          $display("%0t: saturation_scaled expected %0d actual %0d",
                   $time, want.sat, saturation_scaled);
        end
        if (value_scaled !== want.val) begin
          errors++;
          $display("%0t: value_scaled expected %0d actual %0d", $time, want.val, value_scaled);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[filelist.f]
rtl/r2h_pkg.sv
rtl/r2h_front.sv
rtl/r2h_queue.sv
rtl/r2h_back.sv
rtl/rgb_to_hsv_converter.sv
test/tb_rgb_to_hsv_converter.sv
